>>> sv/pllc_pkg.sv
package pllc_pkg;

    localparam int FRAME_BYTES = 17;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W      = $clog2(2 * FRAME_BYTES);

    localparam logic [7:0] CMD_RESET     = 8'd105;
    localparam logic [7:0] CMD_POLL      = 8'h55;
    localparam logic [7:0] CMD_LINE_BASE = 8'd110;
    localparam logic [7:0] PAD_CHAR      = 8'd32;
    localparam logic [7:0] KEY_IDLE      = 8'd200;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_QUERY,
        OP_RESET
    } op_t;

    // one classified word on its way from front to back
    typedef struct packed {
        logic              status;
        logic [7:0]        key_value;
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              mem_we;
        logic              mem_re;
        logic [ADDR_W-1:0] mem_addr;
        logic [7:0]        mem_data;
    } work_t;

endpackage

>>> sv/pllc_front.sv
module pllc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     operation,
    input  logic [1:0]     line_select,
    input  logic           first_char,
    input  logic           char_present,
    input  logic [7:0]     text_char,
    input  logic           last_char,
    input  logic           rx_valid,
    input  logic [7:0]     rx_byte,
    input  logic           queue_full,
    output logic           push,
    output pllc_pkg::work_t push_item
);
    import pllc_pkg::*;

    logic [CNT_W-1:0] cnt_reg  [2];
    logic [CNT_W-1:0] cnt_next [2];
    logic [CNT_W-1:0] idx_reg  [2];
    logic [CNT_W-1:0] idx_next [2];
    logic [CNT_W-1:0] fill_reg [2];
    logic [CNT_W-1:0] fill_next[2];
    logic [7:0]       cmd_reg  [2];
    logic [7:0]       cmd_next [2];
    logic [7:0]       key_reg;
    logic [7:0]       key_next;
    logic             loading_reg;
    logic             loading_next;
    logic             accept;
    work_t            item;

    function automatic logic [ADDR_W-1:0] frame_addr(input logic ln,
                                                     input logic [CNT_W-1:0] idx);
        return ln ? ADDR_W'(FRAME_BYTES) + ADDR_W'(idx) : ADDR_W'(idx);
    endfunction

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign push      = accept;
    assign push_item = item;

    always_comb
    begin
        logic             pending;
        logic             sl;
        logic             open;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] idx_inc;
        logic [CNT_W-1:0] wcnt;

        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        loading_next = loading_reg;
        item         = '0;

        pending = (cnt_reg[0] != '0) || (cnt_reg[1] != '0);
        sl      = (cnt_reg[0] == '0);
        open    = loading_reg;
        idx     = idx_reg[sl];
        idx_inc = '0;
        wcnt    = cnt_reg[sl];

        unique case (op_t'(operation))
            OP_TICK:
            begin
                if (rx_valid)
                    key_next = rx_byte;
                if (!loading_reg && pending)
                begin
                    if (idx >= CNT_W'(FRAME_BYTES))
                        idx = CNT_W'(FRAME_BYTES - 1);
                    item.tx_valid = 1'b1;
                    // command byte in a register, text in memory, padding implied
                    if (idx == '0)
                        item.tx_byte = cmd_reg[sl];
                    else if (idx < fill_reg[sl])
                    begin
                        item.mem_re   = 1'b1;
                        item.mem_addr = frame_addr(sl, idx);
                    end
                    else
                        item.tx_byte = PAD_CHAR;
                    idx_inc = idx + 1'b1;
                    if (idx_inc >= cnt_reg[sl])
                    begin
                        cnt_next[sl] = '0;
                        idx_next[sl] = '0;
                    end
                    else
                        idx_next[sl] = idx_inc;
                end
            end
            OP_WRITE:
            begin
                if (first_char)
                begin
                    if (loading_reg)
                    begin
                        // restart abandons the open write
                        cnt_next[0]  = '0;
                        cnt_next[1]  = '0;
                        idx_next[0]  = '0;
                        idx_next[1]  = '0;
                        loading_next = 1'b0;
                    end
                    if (!loading_reg && pending)
                    begin
                        item.status = 1'b1;
                        open        = 1'b0;
                    end
                    else
                    begin
                        sl           = (line_select != 2'd1);
                        cmd_next[sl] = CMD_LINE_BASE + {6'b0, line_select};
                        idx_next[sl] = '0;
                        wcnt         = CNT_W'(1);
                        loading_next = 1'b1;
                        open         = 1'b1;
                    end
                end
                else if (!open)
                    item.status = 1'b1;

                if (open)
                begin
                    if (char_present && wcnt < CNT_W'(FRAME_BYTES))
                    begin
                        item.mem_we   = 1'b1;
                        item.mem_addr = frame_addr(sl, wcnt);
                        item.mem_data = text_char;
                        wcnt          = wcnt + 1'b1;
                    end
                    fill_next[sl] = wcnt;
                    if (last_char)
                    begin
                        cnt_next[sl] = CNT_W'(FRAME_BYTES);
                        loading_next = 1'b0;
                    end
                    else
                        cnt_next[sl] = wcnt;
                end
            end
            OP_QUERY:
            begin
                if (key_reg != '0)
                begin
                    item.key_value = (key_reg == KEY_IDLE) ? 8'd0 : key_reg;
                    key_next       = '0;
                end
                else
                begin
                    item.status = 1'b1;
                    if (!pending)
                    begin
                        cmd_next[0] = CMD_POLL;
                        cnt_next[0] = CNT_W'(1);
                        idx_next[0] = '0;
                    end
                end
            end
            OP_RESET:
            begin
                if (!pending)
                begin
                    cmd_next[0] = CMD_RESET;
                    cnt_next[0] = CNT_W'(1);
                    idx_next[0] = '0;
                end
                else
                    item.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
            idx_reg[0]  <= '0;
            idx_reg[1]  <= '0;
            fill_reg[0] <= '0;
            fill_reg[1] <= '0;
            key_reg     <= '0;
            loading_reg <= 1'b0;
        end
        else if (accept)
        begin
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            fill_reg    <= fill_next;
            key_reg     <= key_next;
            loading_reg <= loading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

>>> sv/pllc_queue.sv
module pllc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pllc_pkg::work_t push_item,
    input  logic            pop,
    output pllc_pkg::work_t pop_item,
    output logic            full,
    output logic            empty
);
    import pllc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    work_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> sv/pllc_back.sv
module pllc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  pllc_pkg::work_t pop_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            status,
    output logic [7:0]      key_value,
    output logic            tx_valid,
    output logic [7:0]      tx_byte
);
    import pllc_pkg::*;

    logic [7:0] text_mem [2 * FRAME_BYTES];
    logic       out_valid_reg;
    logic       status_reg;
    logic [7:0] key_reg;
    logic       tx_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       from_mem_reg;
    logic [7:0] rd_data_reg;

    // output register empty or draining this cycle
    assign pop = !empty && (!out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign key_value = key_reg;
    assign tx_valid  = tx_valid_reg;
    assign tx_byte   = from_mem_reg ? rd_data_reg : tx_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg   <= pop_item.status;
            key_reg      <= pop_item.key_value;
            tx_valid_reg <= pop_item.tx_valid;
            tx_byte_reg  <= pop_item.tx_byte;
            from_mem_reg <= pop_item.mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_item.mem_we)
            text_mem[pop_item.mem_addr] <= pop_item.mem_data;
        if (pop && pop_item.mem_re)
            rd_data_reg <= text_mem[pop_item.mem_addr];
    end

endmodule

>>> sv/panel_line_link_controller.sv
// panel line link controller
//
// input channel (in_valid / in_stall) carries one word per operation: tick,
// line write item, key query or panel reset, with the write and receive fields
// alongside. the output channel (out_valid / out_stall) returns exactly one
// result word per input word, in order: status, key_value, tx_valid, tx_byte.
//
// the front updates all control state at accept and pushes a classified word
// into a 2-entry queue; the back then pops it, performs the single text
// memory access and loads the output register. throughput is 1 word per
// cycle while the receiver does not stall, set by the one memory port in
// the back.
//
// when the receiver stalls, the output register holds its word and the queue
// fills; in_stall rises only once both queue entries are taken.
// reset clears line counts, indexes, latched key and the write-open flag;
// the text memory needs no clearing pass, since only written bytes are ever
// sent.
module panel_line_link_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [1:0] line_select,
    input  logic       first_char,
    input  logic       char_present,
    input  logic [7:0] text_char,
    input  logic       last_char,
    input  logic       rx_valid,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       status,
    output logic [7:0] key_value,
    output logic       tx_valid,
    output logic [7:0] tx_byte
);
    import pllc_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    work_t push_item;
    work_t pop_item;

    pllc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .line_select  (line_select),
        .first_char   (first_char),
        .char_present (char_present),
        .text_char    (text_char),
        .last_char    (last_char),
        .rx_valid     (rx_valid),
        .rx_byte      (rx_byte),
        .queue_full   (full),
        .push         (push),
        .push_item    (push_item)
    );

    pllc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (full),
        .empty     (empty)
    );

    pllc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .key_value (key_value),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte)
    );

endmodule

>>> dv/tb.sv
module tb;
    import pllc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        logic       is_first;
        logic       present;
        logic [7:0] ch;
        logic       is_last;
        logic       rxv;
        logic [7:0] rxb;
    } panel_word_t;

    typedef struct packed {
        logic       status;
        logic [7:0] key;
        logic       txv;
        logic [7:0] txb;
    } reply_t;

    typedef struct packed {
        panel_word_t w;
        logic [4:0]  reps;
        logic        has_want;
        reply_t      want;
    } dir_row_t;

    // directed words: where has_want is set the reply is written out, else predicted
    localparam dir_row_t DIRECTED [26] = '{
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_QUERY, 2'd1, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_QUERY, 2'd2, 1, 1, 8'hff, 1, 1, 8'hff},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_RESET, 2'd3, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 1, 8'd200}, 1, 1, '{0, 8'h00, 1, CMD_POLL}},
        '{'{OP_QUERY, 2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_RESET, 2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd1, 1, 1, 8'h41, 0, 0, 8'h00},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd1, 0, 1, 8'hff, 0, 0, 8'h00},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 1, 8'h00},  1, 1, '{0, 8'h00, 1, CMD_RESET}},
        '{'{OP_QUERY, 2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 1, 8'hff},  1, 1, '{0, 8'h00, 1, CMD_POLL}},
        '{'{OP_QUERY, 2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{0, 8'hff, 0, 8'h00}},
        '{'{OP_WRITE, 2'd1, 0, 1, 8'h20, 1, 0, 8'h00},  1, 1, '{1, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd1, 1, 1, 8'h00, 0, 0, 8'h00},  1, 1, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 1, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd3, 1, 1, 8'h41, 0, 0, 8'h00},  1, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd0, 0, 1, 8'h7e, 0, 0, 8'h00}, 18, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd0, 0, 1, 8'h80, 1, 0, 8'h00},  1, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 0, 8'h00}, 18, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd0, 1, 0, 8'h5a, 1, 0, 8'h00},  1, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 0, 8'h00}, 17, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd2, 1, 1, 8'h01, 0, 0, 8'h00},  1, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_WRITE, 2'd0, 0, 0, 8'hff, 1, 0, 8'h00},  1, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_TICK,  2'd0, 0, 0, 8'h00, 0, 1, 8'h80}, 17, 0, '{0, 8'h00, 0, 8'h00}},
        '{'{OP_QUERY, 2'd0, 0, 0, 8'h00, 0, 0, 8'h00},  1, 0, '{0, 8'h00, 0, 8'h00}}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] operation;
    logic [1:0] line_select;
    logic       first_char;
    logic       char_present;
    logic [7:0] text_char;
    logic       last_char;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       status;
    logic [7:0] key_value;
    logic       tx_valid;
    logic [7:0] tx_byte;

    // typed-in reply travels beside the word it belongs to
    logic   want_given;
    reply_t want_reply;

    // predictor state
    logic [7:0]  frame_mem [2*FRAME_BYTES];
    int unsigned next_byte [2];
    int unsigned frame_len [2];
    logic [7:0]  held_key;
    bit          write_open;

    reply_t      pending_replies [$];
    panel_word_t seen_word;
    reply_t      due;
    int          errors = 0;
    int          quiet = 0;
    int          words_sent = 0;
    int          send_idle = 0;
    int          stall_pct = 0;
    logic        hold_kick = 1'b0;
    logic        kick_seen = 1'b0;
    int          hold_left = 0;

    panel_line_link_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .line_select  (line_select),
        .first_char   (first_char),
        .char_present (char_present),
        .text_char    (text_char),
        .last_char    (last_char),
        .rx_valid     (rx_valid),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .key_value    (key_value),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte)
    );

    always #6 clk = ~clk;

    function automatic bit frames_waiting();
        return frame_len[0] != 0 || frame_len[1] != 0;
    endfunction

    function automatic void queue_single_byte(input logic [7:0] b);
        frame_mem[0] = b;
        frame_len[0] = 1;
        next_byte[0] = 0;
    endfunction

    function automatic reply_t predict_panel_reply(input panel_word_t w);
        reply_t      r;
        int          ln;
        int unsigned idx;
        int unsigned cnt;
        bit          accepting;
        r = '0;
        case (w.op)
            OP_TICK:
            begin
                if (w.rxv)
                    held_key = w.rxb;
                if (!write_open && frames_waiting())
                begin
                    ln  = (frame_len[0] != 0) ? 0 : 1;
                    idx = next_byte[ln];
                    if (idx >= FRAME_BYTES)
                        idx = FRAME_BYTES - 1;
                    r.txv = 1'b1;
                    r.txb = frame_mem[ln*FRAME_BYTES + idx];
                    next_byte[ln] = idx + 1;
                    if (next_byte[ln] >= frame_len[ln])
                    begin
                        frame_len[ln] = 0;
                        next_byte[ln] = 0;
                    end
                end
            end
            OP_WRITE:
            begin
                accepting = write_open;
                if (w.is_first)
                begin
                    // a new first word abandons an open write
                    if (write_open)
                    begin
                        frame_len  = '{0, 0};
                        next_byte  = '{0, 0};
                        write_open = 1'b0;
                    end
                    if (frames_waiting())
                    begin
                        accepting = 1'b0;
                        r.status  = 1'b1;
                    end
                    else
                    begin
                        ln = (w.sel == 2'd1) ? 0 : 1;
                        frame_mem[ln*FRAME_BYTES] = CMD_LINE_BASE + 8'(w.sel);
                        frame_len[ln] = 1;
                        next_byte[ln] = 0;
                        write_open = 1'b1;
                        accepting  = 1'b1;
                    end
                end
                else if (!accepting)
                    r.status = 1'b1;
                if (accepting)
                begin
                    ln  = (frame_len[0] != 0) ? 0 : 1;
                    cnt = frame_len[ln];
                    if (w.present && cnt < FRAME_BYTES)
                    begin
                        frame_mem[ln*FRAME_BYTES + cnt] = w.ch;
                        cnt++;
                    end
                    if (w.is_last)
                    begin
                        while (cnt < FRAME_BYTES)
                        begin
                            frame_mem[ln*FRAME_BYTES + cnt] = PAD_CHAR;
                            cnt++;
                        end
                        write_open = 1'b0;
                    end
                    frame_len[ln] = cnt;
                end
            end
            OP_QUERY:
            begin
                if (held_key != 8'd0)
                begin
                    r.key    = (held_key == KEY_IDLE) ? 8'd0 : held_key;
                    held_key = 8'd0;
                end
                else
                begin
                    r.status = 1'b1;
                    if (!frames_waiting())
                        queue_single_byte(CMD_POLL);
                end
            end
            default:
            begin
                if (!frames_waiting())
                    queue_single_byte(CMD_RESET);
                else
                    r.status = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic panel_word_t rand_word();
        panel_word_t w;
        w.op       = op_t'($urandom_range(3));
        w.sel      = 2'($urandom_range(3));
        w.is_first = 1'($urandom_range(1));
        w.present  = 1'($urandom_range(1));
        w.ch       = 8'($urandom_range(255));
        w.is_last  = 1'($urandom_range(1));
        w.rxv      = 1'($urandom_range(1));
        w.rxb      = 8'($urandom_range(255));
        return w;
    endfunction

    task automatic put_word(input panel_word_t w, input logic given = 1'b0,
                            input reply_t want = '0);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= w.op;
        line_select  <= w.sel;
        first_char   <= w.is_first;
        char_present <= w.present;
        text_char    <= w.ch;
        last_char    <= w.is_last;
        rx_valid     <= w.rxv;
        rx_byte      <= w.rxb;
        want_given   <= given;
        want_reply   <= want;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_ticks(input int n);
        panel_word_t w;
        repeat (n)
        begin
            w    = rand_word();
            w.op = OP_TICK;
            put_word(w);
        end
    endtask

    task automatic play_random(input int n);
        int          target;
        int          kind;
        int          m;
        panel_word_t w;
        target = words_sent + n;
        while (words_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                // line write with random text, then drain it
                m = $urandom_range(1, 19);
                for (int i = 0; i < m; i++)
                begin
                    if ($urandom_range(19) == 0)
                        send_ticks(1);
                    w          = rand_word();
                    w.op       = OP_WRITE;
                    w.is_first = (i == 0);
                    w.is_last  = (i == m - 1) && ($urandom_range(9) != 0);
                    w.present  = ($urandom_range(9) != 0);
                    if (i == 0 && $urandom_range(3) != 0)
                        w.sel = 2'($urandom_range(1, 2));
                    put_word(w);
                end
                send_ticks($urandom_range(14, 20));
            end
            else if (kind < 55)
            begin
                w    = rand_word();
                w.op = OP_QUERY;
                put_word(w);
                send_ticks($urandom_range(1, 3));
            end
            else if (kind < 63)
            begin
                w    = rand_word();
                w.op = OP_RESET;
                put_word(w);
                send_ticks(1);
            end
            else if (kind < 85)
                send_ticks($urandom_range(1, 5));
            else
                repeat ($urandom_range(1, 3))
                    put_word(rand_word());
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, exp_v, got_v);
        end
    endtask

    // receiver: random stall, or a long hold-off when kicked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            kick_seen <= 1'b0;
        end
        else if (hold_kick != kick_seen)
        begin
            kick_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen_word = '{op_t'(operation), line_select, first_char, char_present,
                              text_char, last_char, rx_valid, rx_byte};
                due = predict_panel_reply(seen_word);
                pending_replies.push_back(want_given ? want_reply : due);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reply status %0b key %0h tx %0b/%0h",
                             $time, status, key_value, tx_valid, tx_byte);
                end
                else
                begin
                    due = pending_replies.pop_front();
                    compare_field("status", 8'(due.status), 8'(status));
                    compare_field("key_value", due.key, key_value);
                    compare_field("tx_valid", 8'(due.txv), 8'(tx_valid));
                    compare_field("tx_byte", due.txb, tx_byte);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet + 1 >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = '0;
        line_select  = '0;
        first_char   = 1'b0;
        char_present = 1'b0;
        text_char    = '0;
        last_char    = 1'b0;
        rx_valid     = 1'b0;
        rx_byte      = '0;
        want_given   = 1'b0;
        want_reply   = '0;
        for (int i = 0; i < 2*FRAME_BYTES; i++)
            frame_mem[i] = '0;
        next_byte  = '{0, 0};
        frame_len  = '{0, 0};
        held_key   = '0;
        write_open = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < $size(DIRECTED); r++)
            for (int k = 0; k < DIRECTED[r].reps; k++)
                put_word(DIRECTED[r].w, DIRECTED[r].has_want, DIRECTED[r].want);

        play_random(350);
        send_idle = 86;
        play_random(350);
        send_idle = 0;
        stall_pct = 86;
        play_random(350);
        send_idle = 32;
        stall_pct = 32;
        play_random(350);
        // long receiver hold-off while words keep coming, so the input backs up
        send_idle = 0;
        stall_pct = 0;
        hold_kick <= ~hold_kick;
        play_random(300);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
